// File: sv/assert_macros.svh
// Shared assertion macros for the coverage accumulator checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FRCA_ASSERT_NOW(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("frca: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FRCA_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("frca: next-cycle check failed");

`endif

// File: sv/frca_pkg.sv
package frca_pkg;

	// Function codes of a command word.
	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_ALIGN = 2'd1;
	localparam logic [1:0] FUNC_END   = 2'd2;
	localparam logic [1:0] FUNC_READ  = 2'd3;

	// Status codes of a response word.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_INDEX  = 3'd1;
	localparam logic [2:0] ST_BAD_POS    = 3'd2;
	localparam logic [2:0] ST_GROUP_FULL = 3'd3;
	localparam logic [2:0] ST_TABLE_FULL = 3'd4;

	// A buffered alignment: transcript index and start position.
	localparam int GRP_W = 28;

	typedef struct packed {
		logic [1:0]  func;
		logic        new_read;
		logic [11:0] txp_index;
		logic [15:0] position;
		logic [15:0] mate_position;
		logic [15:0] txp_length;
		logic [31:0] abundance;
	} cmd_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] coverage;
		logic [6:0]  flushed_count;
	} rsp_word_t;

endpackage

// File: sv/frca_ram.sv
module frca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: sv/fractional_read_coverage_accumulator_core.sv
// Channel   | Signals                    | Handshake
// ----------+----------------------------+-------------------------------------
// command   | start, busy, cmd           | word taken when start && !busy
// response  | done, rsp                  | word valid for the one cycle of done
//
// After reset the coverage memory is cleared one word a cycle, with busy
// high. A load or an invalid item is answered from S_DISPATCH; a read in
// range goes on through S_COVRD, and a valid alignment through S_APPEND,
// after a flush when it opens a new read. A flush walks the buffered group
// and, per alignment, does a group read, a table read, 17 steps of the
// iterative divider and a write back.
// The receiver cannot stall; a new word may be taken while done is shown.
module fractional_read_coverage_accumulator_core #(
	parameter int NUM_TRANSCRIPTS    = 4096,
	parameter int MAX_TRANSCRIPT_LEN = 65535,
	parameter int COVERAGE_DEPTH     = 1048576,
	parameter int GROUP_MAX          = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  frca_pkg::cmd_word_t  cmd,
	output logic                 done,
	output frca_pkg::rsp_word_t  rsp
);
	localparam int TA   = (NUM_TRANSCRIPTS > 1) ? $clog2(NUM_TRANSCRIPTS) : 1;
	localparam int LCW  = $clog2(NUM_TRANSCRIPTS + 1);
	localparam int CW   = $clog2(COVERAGE_DEPTH);
	localparam int BW   = CW + 1;
	localparam int AXW  = ((BW > 16) ? BW : 16) + 1;
	localparam int TBW  = 16 + BW + 32;
	localparam int GW   = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
	localparam int GCW  = $clog2(GROUP_MAX + 1);
	localparam int SW   = 32 + GCW;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DISPATCH, S_APPEND, S_COVRD,
		S_FL_START, S_FL_RDG, S_FL_RDT, S_FL_DIV0, S_FL_DIV, S_FL_WR
	} state_t;

	state_t                state_q;
	frca_pkg::cmd_word_t   item_q;
	frca_pkg::rsp_word_t   res_q;
	logic                  done_q;
	logic [CW-1:0]         clr_q;
	logic [LCW-1:0]        loaded_q;
	logic [BW-1:0]         next_base_q;
	logic [GCW-1:0]        gsize_q;
	logic [SW-1:0]         sum_q;
	logic [15:0]           start_pos_q;
	logic [31:0]           abun_q;
	logic                  ret_append_q;
	logic [GCW-1:0]        k_q;
	logic [15:0]           fpos_q;
	logic [AXW-1:0]        faddr_q;
	logic                  faddr_ok_q;
	logic [SW-1:0]         rem_q;
	logic                  lsb_q;
	logic [16:0]           quo_q;
	logic [4:0]            dcnt_q;

	// Memory ports.
	logic                  tbl_we, tbl_re;
	logic [TA-1:0]         tbl_waddr, tbl_raddr;
	logic [TBW-1:0]        tbl_wdata, tbl_rdata;
	logic                  grp_we, grp_re;
	logic [GW-1:0]         grp_waddr, grp_raddr;
	logic [frca_pkg::GRP_W-1:0] grp_wdata, grp_rdata;
	logic                  cov_we, cov_re;
	logic [CW-1:0]         cov_waddr, cov_raddr;
	logic [31:0]           cov_wdata, cov_rdata;

	// Decoded table entry.
	logic [15:0]           t_len;
	logic [BW-1:0]         t_base;
	logic [31:0]           t_abun;
	assign t_abun = tbl_rdata[31:0];
	assign t_base = tbl_rdata[BW+31:32];
	assign t_len  = tbl_rdata[TBW-1:BW+32];

	// Load checks.
	logic [15:0]           len_clamped;
	logic                  load_full;
	always_comb begin
		len_clamped = item_q.txp_length;
		if (32'(item_q.txp_length) > 32'(MAX_TRANSCRIPT_LEN)) begin
			len_clamped = 16'(MAX_TRANSCRIPT_LEN);
		end
		load_full = (32'(loaded_q) >= 32'(NUM_TRANSCRIPTS)) ||
			((AXW'(next_base_q) + AXW'(len_clamped)) > AXW'(COVERAGE_DEPTH));
	end

	// Alignment and read checks against the fetched table entry.
	logic                  idx_ok, pos_ok, rd_addr_ok, fl_addr_ok;
	logic [AXW-1:0]        rd_addr, fl_addr;
	logic [15:0]           min_pos;
	assign idx_ok     = 32'(item_q.txp_index) < 32'(loaded_q);
	assign pos_ok     = item_q.position < t_len;
	assign rd_addr    = AXW'(t_base) + AXW'(item_q.position);
	assign rd_addr_ok = rd_addr < AXW'(COVERAGE_DEPTH);
	assign fl_addr    = AXW'(t_base) + AXW'(fpos_q);
	assign fl_addr_ok = fl_addr < AXW'(COVERAGE_DEPTH);
	assign min_pos    = (item_q.mate_position < item_q.position) ?
		item_q.mate_position : item_q.position;

	// One restoring division step.
	logic [SW:0]           trial;
	logic                  trial_ge;
	logic [32:0]           cov_sum;
	assign trial    = {rem_q, (dcnt_q == 5'd16) ? lsb_q : 1'b0};
	assign trial_ge = trial >= {1'b0, sum_q};
	assign cov_sum  = {1'b0, cov_rdata} + 33'(quo_q);

	// Memory control.
	always_comb begin
		tbl_re    = (state_q == S_IDLE && start) || state_q == S_FL_RDT;
		tbl_raddr = (state_q == S_IDLE) ? TA'(cmd.txp_index) :
			TA'(grp_rdata[frca_pkg::GRP_W-1:16]);
		tbl_we    = state_q == S_DISPATCH && item_q.func == frca_pkg::FUNC_LOAD &&
			!load_full;
		tbl_waddr = TA'(loaded_q);
		tbl_wdata = {len_clamped, next_base_q, item_q.abundance};
		grp_re    = state_q == S_FL_RDG;
		grp_raddr = k_q[GW-1:0];
		grp_we    = state_q == S_APPEND && 32'(gsize_q) < 32'(GROUP_MAX);
		grp_waddr = gsize_q[GW-1:0];
		grp_wdata = {item_q.txp_index, start_pos_q};
		cov_we    = state_q == S_CLEAR || (state_q == S_FL_WR && faddr_ok_q);
		cov_waddr = (state_q == S_CLEAR) ? clr_q : faddr_q[CW-1:0];
		cov_wdata = '0;
		if (state_q != S_CLEAR) begin
			cov_wdata = cov_sum[32] ? 32'hFFFF_FFFF : cov_sum[31:0];
		end
		cov_re    = (state_q == S_DISPATCH && item_q.func == frca_pkg::FUNC_READ &&
			idx_ok && pos_ok && rd_addr_ok) || (state_q == S_FL_DIV0 && fl_addr_ok);
		cov_raddr = (state_q == S_DISPATCH) ? rd_addr[CW-1:0] : fl_addr[CW-1:0];
	end

	// Sequencer with registered response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			done_q       <= 1'b0;
			clr_q        <= '0;
			loaded_q     <= '0;
			next_base_q  <= '0;
			gsize_q      <= '0;
			sum_q        <= '0;
			ret_append_q <= 1'b0;
			k_q          <= '0;
			dcnt_q       <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == COVERAGE_DEPTH - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						item_q  <= cmd;
						res_q   <= '0;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (item_q.func)
						frca_pkg::FUNC_LOAD: begin
							if (load_full) begin
								res_q.status <= frca_pkg::ST_TABLE_FULL;
							end else begin
								loaded_q    <= loaded_q + 1'b1;
								next_base_q <= next_base_q + BW'(len_clamped);
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						frca_pkg::FUNC_END: begin
							ret_append_q <= 1'b0;
							state_q      <= S_FL_START;
						end
						default: begin
							if (!idx_ok) begin
								res_q.status <= frca_pkg::ST_BAD_INDEX;
								done_q       <= 1'b1;
								state_q      <= S_IDLE;
							end else if (!pos_ok) begin
								res_q.status <= frca_pkg::ST_BAD_POS;
								done_q       <= 1'b1;
								state_q      <= S_IDLE;
							end else if (item_q.func == frca_pkg::FUNC_READ) begin
								if (rd_addr_ok) begin
									state_q <= S_COVRD;
								end else begin
									done_q  <= 1'b1;
									state_q <= S_IDLE;
								end
							end else begin
								start_pos_q  <= min_pos;
								abun_q       <= t_abun;
								ret_append_q <= 1'b1;
								if (item_q.new_read && gsize_q != '0) begin
									state_q <= S_FL_START;
								end else begin
									state_q <= S_APPEND;
								end
							end
						end
					endcase
				end
				S_APPEND: begin
					if (32'(gsize_q) >= 32'(GROUP_MAX)) begin
						res_q.status <= frca_pkg::ST_GROUP_FULL;
					end else begin
						gsize_q <= gsize_q + 1'b1;
						sum_q   <= sum_q + SW'(abun_q);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_COVRD: begin
					res_q.coverage <= cov_rdata;
					done_q         <= 1'b1;
					state_q        <= S_IDLE;
				end
				S_FL_START: begin
					k_q <= '0;
					if (gsize_q == '0 || sum_q == '0) begin
						res_q.flushed_count <= 7'(gsize_q);
						gsize_q <= '0;
						sum_q   <= '0;
						if (ret_append_q) begin
							state_q <= S_APPEND;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_FL_RDG;
					end
				end
				S_FL_RDG: begin
					state_q <= S_FL_RDT;
				end
				S_FL_RDT: begin
					fpos_q  <= grp_rdata[15:0];
					state_q <= S_FL_DIV0;
				end
				S_FL_DIV0: begin
					faddr_q    <= fl_addr;
					faddr_ok_q <= fl_addr_ok;
					rem_q      <= SW'(t_abun[31:1]);
					lsb_q      <= t_abun[0];
					quo_q      <= '0;
					dcnt_q     <= 5'd16;
					state_q    <= S_FL_DIV;
				end
				S_FL_DIV: begin
					rem_q  <= trial_ge ? SW'(trial - {1'b0, sum_q}) : SW'(trial);
					quo_q  <= {quo_q[15:0], trial_ge};
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == '0) begin
						state_q <= S_FL_WR;
					end
				end
				S_FL_WR: begin
					k_q <= k_q + 1'b1;
					if (k_q + 1'b1 == gsize_q) begin
						res_q.flushed_count <= 7'(gsize_q);
						gsize_q <= '0;
						sum_q   <= '0;
						if (ret_append_q) begin
							state_q <= S_APPEND;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_FL_RDG;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = res_q;

	// Transcript table: length, base and abundance per loaded transcript.
	frca_ram #(.WIDTH(TBW), .DEPTH(NUM_TRANSCRIPTS)) u_tbl (
		.clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
		.re(tbl_re), .raddr(tbl_raddr), .rdata(tbl_rdata)
	);

	// Alignments of the current read group.
	frca_ram #(.WIDTH(frca_pkg::GRP_W), .DEPTH(GROUP_MAX)) u_grp (
		.clk(clk), .we(grp_we), .waddr(grp_waddr), .wdata(grp_wdata),
		.re(grp_re), .raddr(grp_raddr), .rdata(grp_rdata)
	);

	// Flat coverage memory.
	frca_ram #(.WIDTH(32), .DEPTH(COVERAGE_DEPTH)) u_cov (
		.clk(clk), .we(cov_we), .waddr(cov_waddr), .wdata(cov_wdata),
		.re(cov_re), .raddr(cov_raddr), .rdata(cov_rdata)
	);
endmodule

// File: sv/frca_checker.sv
`include "assert_macros.svh"

module frca_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input frca_pkg::rsp_word_t  rsp
);
	logic accept;
	logic fail_done;
	logic status_known;
	assign accept = start && !busy;
	assign fail_done = done && rsp.status != frca_pkg::ST_OK;
	assign status_known = rsp.status == frca_pkg::ST_OK ||
		rsp.status == frca_pkg::ST_BAD_INDEX || rsp.status == frca_pkg::ST_BAD_POS ||
		rsp.status == frca_pkg::ST_GROUP_FULL || rsp.status == frca_pkg::ST_TABLE_FULL;

	// An accepted word keeps the block busy until its response.
	`FRCA_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy)
	// A response is only shown once the block is free again.
	`FRCA_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)
	// Responses never come in consecutive cycles.
	`FRCA_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	// A failed item carries no coverage word.
	`FRCA_ASSERT_NOW(a_fail_nocov, clk, arst_n, fail_done, rsp.coverage == 32'd0)
	// Only defined status codes are reported.
	`FRCA_ASSERT_NOW(a_status_known, clk, arst_n, done, status_known)
endmodule

bind fractional_read_coverage_accumulator_core frca_checker u_frca_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .rsp(rsp)
);
